// ----- src/integer_to_ascii_formatter_defines.svh -----
// Assertion helpers for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define I2A_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2a assertion failed");
// Next-cycle implication, disabled while reset is held.
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2a assertion failed");
`else
`define I2A_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/i2a_pkg.sv -----
`default_nettype none

package i2a_pkg;

  localparam int OP_W      = 2;
  localparam int VALUE_W   = 64;
  localparam int CHAR_W    = 7;
  localparam int DIG_W     = 4;
  localparam int NUM_CELLS = 20;
  localparam int CNT_W     = 7;

  // first cell that receives a nibble when a hex number is loaded
  localparam int HEX64_BASE = NUM_CELLS - 16;
  localparam int HEX32_BASE = NUM_CELLS - 8;

  localparam logic [CNT_W-1:0] UDEC_BITS   = CNT_W'(64);
  localparam logic [CNT_W-1:0] SDEC_BITS   = CNT_W'(32);
  localparam logic [CNT_W-1:0] HEX64_DIGS  = CNT_W'(16);
  localparam logic [CNT_W-1:0] HEX32_DIGS  = CNT_W'(8);
  localparam logic [CNT_W-1:0] DEC_DIGS    = CNT_W'(NUM_CELLS);

  localparam logic [DIG_W-1:0] DEC_RADIX   = 4'd10;
  localparam logic [DIG_W-1:0] DABBLE_LIM  = 4'd5;
  localparam logic [DIG_W-1:0] DABBLE_ADD  = 4'd3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;

  typedef enum logic [OP_W-1:0] {
    OP_UDEC  = 2'd0,
    OP_SDEC  = 2'd1,
    OP_HEX32 = 2'd2,
    OP_HEX64 = 2'd3
  } op_t;

  // per-cycle command to every cell of the digit row
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DEC_RADIX) begin
      ch = CHAR_ZERO + {{(CHAR_W-DIG_W){1'b0}}, d};
    end else begin
      ch = CHAR_A + {{(CHAR_W-DIG_W){1'b0}}, d} - {{(CHAR_W-DIG_W){1'b0}}, DEC_RADIX};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- src/i2a_in_if.sv -----
`default_nettype none

interface i2a_in_if import i2a_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [VALUE_W-1:0]   value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// ----- src/i2a_out_if.sv -----
`default_nettype none

interface i2a_out_if import i2a_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    character;
  logic                 last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ----- src/i2a_cell.sv -----
`default_nettype none

// One digit of the row: load, shift-and-add-3 step, or hand the digit upward.
module i2a_cell import i2a_pkg::*; (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [DIG_W-1:0] load_digit,
  input  wire logic             bit_in,
  input  wire logic [DIG_W-1:0] nib_in,
  output logic      [DIG_W-1:0] digit,
  output logic                  carry_out
);

  logic [DIG_W-1:0] digit_r;
  logic [DIG_W-1:0] adj;

  // correct before the doubling so the digit stays decimal
  assign adj       = (digit_r >= DABBLE_LIM) ? (digit_r + DABBLE_ADD) : digit_r;
  assign carry_out = adj[DIG_W-1];
  assign digit     = digit_r;

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      digit_r <= load_digit;
    end else if (ctl.dabble) begin
      digit_r <= {adj[DIG_W-2:0], bit_in};
    end else if (ctl.shift) begin
      digit_r <= nib_in;
    end else begin
      digit_r <= digit_r;
    end
  end

endmodule

`default_nettype wire

// ----- src/integer_to_ascii_formatter.sv -----
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"

// Integer to ASCII formatter. Takes one item {op, value} and returns its text one
// character per output item, most significant first, with last set on the final
// character. op selects unsigned 64-bit decimal (no leading zeros, a lone '0' for
// zero), signed 32-bit decimal (a '-' before the magnitude of a negative number),
// or hex of 32 or 64 bits ("0x" and 8 or 16 uppercase digits). The digits live in
// a row of twenty 4-bit cells. For decimal the binary value is fed into the bottom
// cell one bit a cycle and every cell performs a shift-and-add-3 step, passing its
// carry to the cell above, for each of the 64 bits (unsigned) or 32 bits (signed).
// Leading zeros then drop off the top at one cell a cycle, and each emitted digit
// is taken from the top cell while the row shifts up by one. Hex nibbles load
// straight into the top of the row. The input is taken only once the previous
// item's last character has been loaded into the output register; that register
// lets the next item start while it waits.
module integer_to_ascii_formatter import i2a_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  i2a_in_if.sink   in_ch,
  i2a_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_t;

  // character still owed before the digits
  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_ZERO,
    PFX_X
  } pfx_t;

  state_t             state_r;
  pfx_t               pfx_r;
  op_t                op_r;
  logic [VALUE_W-1:0] bin_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  cell_ctl_t          ctl;
  logic               accept;
  logic               can_load;
  op_t                in_op;
  logic [31:0]        low;
  logic [31:0]        mag;

  logic [DIG_W-1:0]   load_digit [NUM_CELLS];
  logic [DIG_W-1:0]   digit      [NUM_CELLS];
  logic               carry      [NUM_CELLS];
  logic [DIG_W-1:0]   top_digit;

  assign in_op     = op_t'(in_ch.op);
  assign low       = in_ch.value[31:0];
  // magnitude in 32-bit wrap-around, so the most negative value stays exact
  assign mag       = low[31] ? (~low + 32'd1) : low;
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept    = in_ch.valid && in_ch.ready;
  assign can_load  = !out_valid_r || out_ch.ready;
  assign top_digit = digit[NUM_CELLS-1];

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  // drive the row: load on accept, dabble while converting, shift up on skip or emit
  always_comb begin
    ctl = '{load: 1'b0, dabble: 1'b0, shift: 1'b0};
    unique case (state_r)
      S_IDLE: ctl.load   = accept;
      S_CONV: ctl.dabble = 1'b1;
      S_SKIP: ctl.shift  = (top_digit == '0) && (cnt_r > CNT_W'(1));
      S_EMIT: ctl.shift  = can_load && (pfx_r == PFX_NONE);
      default: ctl = '{load: 1'b0, dabble: 1'b0, shift: 1'b0};
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
      logic             bit_in;
      logic [DIG_W-1:0] nib_in;

      // hex nibbles sit top-aligned; decimal starts from an all-zero row
      if (gi >= HEX32_BASE) begin : g_ld32
        assign load_digit[gi] =
          (in_op == OP_HEX64) ? in_ch.value[DIG_W*(gi-HEX64_BASE) +: DIG_W] :
          (in_op == OP_HEX32) ? in_ch.value[DIG_W*(gi-HEX32_BASE) +: DIG_W] : '0;
      end else if (gi >= HEX64_BASE) begin : g_ld64
        assign load_digit[gi] = (in_op == OP_HEX64) ?
                                in_ch.value[DIG_W*(gi-HEX64_BASE) +: DIG_W] : '0;
      end else begin : g_ld0
        assign load_digit[gi] = '0;
      end

      if (gi == 0) begin : g_bottom
        assign bit_in = bin_r[VALUE_W-1];
        assign nib_in = '0;
      end else begin : g_link
        assign bit_in = carry[gi-1];
        assign nib_in = digit[gi-1];
      end

      i2a_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .load_digit (load_digit[gi]),
        .bit_in     (bit_in),
        .nib_in     (nib_in),
        .digit      (digit[gi]),
        .carry_out  (carry[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pfx_r       <= PFX_NONE;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output once taken, unless a new character replaces it below
      if (out_ch.ready && !((state_r == S_EMIT) && can_load)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r <= in_op;
            unique case (in_op)
              OP_UDEC: begin
                bin_r   <= in_ch.value;
                cnt_r   <= UDEC_BITS;
                pfx_r   <= PFX_NONE;
                state_r <= S_CONV;
              end
              OP_SDEC: begin
                // magnitude in the upper half so only 32 steps are needed
                bin_r   <= {mag, 32'h0};
                cnt_r   <= SDEC_BITS;
                pfx_r   <= low[31] ? PFX_MINUS : PFX_NONE;
                state_r <= S_CONV;
              end
              OP_HEX32: begin
                cnt_r   <= HEX32_DIGS;
                pfx_r   <= PFX_ZERO;
                state_r <= S_EMIT;
              end
              OP_HEX64: begin
                cnt_r   <= HEX64_DIGS;
                pfx_r   <= PFX_ZERO;
                state_r <= S_EMIT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        S_CONV: begin
          bin_r <= {bin_r[VALUE_W-2:0], 1'b0};
          if (cnt_r == CNT_W'(1)) begin
            cnt_r   <= DEC_DIGS;
            state_r <= S_SKIP;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end

        S_SKIP: begin
          // hold at least one digit so zero prints as '0'
          if ((top_digit == '0) && (cnt_r > CNT_W'(1))) begin
            cnt_r <= cnt_r - CNT_W'(1);
          end else begin
            state_r <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (can_load) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b0;
            unique case (pfx_r)
              PFX_ZERO: begin
                out_char_r <= CHAR_ZERO;
                pfx_r      <= PFX_X;
              end
              PFX_X: begin
                out_char_r <= CHAR_X;
                pfx_r      <= PFX_NONE;
              end
              PFX_MINUS: begin
                out_char_r <= CHAR_MINUS;
                pfx_r      <= PFX_NONE;
              end
              PFX_NONE: begin
                out_char_r <= digit_char(top_digit);
                cnt_r      <= cnt_r - CNT_W'(1);
                if (cnt_r == CNT_W'(1)) begin
                  out_last_r <= 1'b1;
                  state_r    <= S_IDLE;
                end
              end
              default: pfx_r <= PFX_NONE;
            endcase
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a waiting character stays put until it is taken
  `I2A_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ch.ready,
                   out_valid_r && $stable(out_char_r) && $stable(out_last_r))
  // decimal digits leaving the top cell are always 0..9
  `I2A_ASSERT_IMPL(a_dec_digit, clk, rst_n,
                   (state_r == S_EMIT) && (pfx_r == PFX_NONE) &&
                   ((op_r == OP_UDEC) || (op_r == OP_SDEC)),
                   top_digit < DEC_RADIX)
  // never emit with no digits left
  `I2A_ASSERT_IMPL(a_emit_cnt, clk, rst_n, state_r == S_EMIT, cnt_r != '0)
  // an accepted item always leaves idle
  `I2A_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r != S_IDLE)

endmodule

`default_nettype wire
